// ----- hdl/qat_pkg.sv -----
package qat_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_ARG       = 2'd0,
		KIND_OK        = 2'd1,
		KIND_TOO_MANY  = 2'd2,
		KIND_UNMATCHED = 2'd3
	} kind_t;

	// Characters with a meaning on the line
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	// Capacity after reset
	localparam logic [4:0] MAX_ARGS_RESET = 5'd16;

	// One result beat
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  arg_start;
		logic [8:0]  arg_length;
		logic [3:0]  arg_index;
		logic [4:0]  arg_total;
		logic        last_result;
	} result_t;

endpackage

// ----- hdl/quoted_argument_tokenizer_core.sv -----
// Command line tokenizer.
// Input stream: one character per beat in s_axis_tdata, s_axis_tlast on the final
// byte of a line. Output stream: one beat per argument (offset, length, index,
// running total) with m_axis_tuser = kind, and one status beat per line that
// carries m_axis_tlast. A NUL byte also ends the line; after it or after an error
// the remaining bytes of the line give nothing until the final byte.
// Capacity is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce it. An accepted byte is
// held in the input register and its results are written from there into a
// four-entry result queue, from whose head the result beats leave. One byte is
// taken per cycle as long as the queue has room for the two results a byte can
// cause; when the receiver stalls, the queue fills and s_axis_tready drops until
// it drains.
// Reset clears the line state and the queue and sets the capacity to 16.
module quoted_argument_tokenizer_core #(
	parameter int LINE_BYTES = 256,
	parameter int MAX_ARGS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// capacity register
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  logic        s_axis_tlast,   // last_byte
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] arg_start, [16:8] arg_length,
	                                    // [20:17] arg_index, [25:21] arg_total, zero pad
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // last_result
);

	localparam int POS_W = (LINE_BYTES > 2) ? $clog2(LINE_BYTES) : 1;
	localparam int EXT_W = (POS_W + 1 > 9) ? POS_W + 1 : 9;
	localparam logic [POS_W-1:0] POS_END = POS_W'(LINE_BYTES - 1);
	localparam logic [8:0] MAX_ARGS_9 = 9'(MAX_ARGS);

	// Capacity register
	logic [4:0] max_args_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q <= qat_pkg::MAX_ARGS_RESET;
		end else if (cfg_we) begin
			max_args_q <= cfg_wdata;
		end
	end

	// Input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_byte_s1;
	logic       fire_s1;
	logic [2:0] q_count_q;

	assign fire_s1       = valid_s1 && (q_count_q <= 3'd2);
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1      <= s_axis_tdata;
			last_byte_s1 <= s_axis_tlast;
		end
	end

	// Line state
	logic             in_quote_q;
	logic             dbl_q;
	logic             in_arg_q;
	logic [7:0]       begin_q;
	logic [POS_W-1:0] pos_q;
	logic [4:0]       arg_cnt_q;
	logic             stopped_q;

	// Capacity limited by the build-time maximum
	logic [4:0] cap;
	assign cap = ({4'd0, max_args_q} < MAX_ARGS_9) ? max_args_q : MAX_ARGS_9[4:0];

	logic [EXT_W-1:0] pos_ext;
	logic [EXT_W-1:0] pos_p1;
	logic             line_end;
	logic             full;

	assign pos_ext  = EXT_W'(pos_q);
	assign pos_p1   = pos_ext + EXT_W'(1);
	assign line_end = last_byte_s1 || (pos_q == POS_END);
	assign full     = (arg_cnt_q >= cap);

	// Per-byte decode: at most one argument and one status
	logic             n_in_quote;
	logic             n_dbl;
	logic             n_in_arg;
	logic [7:0]       n_begin;
	logic             attempt;
	logic [4:0]       cnt1;
	logic             has_arg;
	logic             has_st;
	qat_pkg::kind_t   st_kind;
	logic [7:0]       arg_beg;
	logic [EXT_W-1:0] arg_end;
	logic [EXT_W-1:0] arg_len;
	logic [4:0]       cnt_after;
	logic [7:0]       quote_ch;

	always_comb begin
		n_in_quote = in_quote_q;
		n_dbl      = dbl_q;
		n_in_arg   = in_arg_q;
		n_begin    = begin_q;
		attempt    = 1'b0;
		cnt1       = arg_cnt_q;
		has_arg    = 1'b0;
		has_st     = 1'b0;
		st_kind    = qat_pkg::KIND_OK;
		arg_beg    = begin_q;
		arg_end    = pos_ext;
		quote_ch   = dbl_q ? qat_pkg::CH_DQUOTE : qat_pkg::CH_SQUOTE;

		if (!stopped_q) begin
			if (char_s1 == qat_pkg::CH_NUL) begin
				// NUL ends the line; open unquoted argument ends before it
				has_st = 1'b1;
				if (in_arg_q && full) begin
					st_kind = qat_pkg::KIND_TOO_MANY;
				end else if (in_quote_q) begin
					st_kind = qat_pkg::KIND_UNMATCHED;
				end else begin
					has_arg = in_arg_q;
					st_kind = qat_pkg::KIND_OK;
				end
			end else begin
				if (in_quote_q) begin
					if (char_s1 == quote_ch) begin
						attempt    = 1'b1;
						n_in_quote = 1'b0;
						n_in_arg   = 1'b0;
					end
				end else if (char_s1 == qat_pkg::CH_SQUOTE ||
				             char_s1 == qat_pkg::CH_DQUOTE) begin
					attempt    = in_arg_q;
					n_in_quote = 1'b1;
					n_dbl      = (char_s1 == qat_pkg::CH_DQUOTE);
					n_in_arg   = 1'b1;
					n_begin    = pos_p1[7:0];
				end else if (char_s1 == qat_pkg::CH_SPACE) begin
					if (in_arg_q) begin
						attempt  = 1'b1;
						n_in_arg = 1'b0;
					end
				end else if (!in_arg_q) begin
					n_in_arg = 1'b1;
					n_begin  = pos_ext[7:0];
				end

				if (attempt && full) begin
					has_st  = 1'b1;
					st_kind = qat_pkg::KIND_TOO_MANY;
				end else begin
					has_arg = attempt;
					cnt1    = arg_cnt_q + 5'(attempt);
					if (line_end) begin
						// final byte closes the line
						has_st = 1'b1;
						if (n_in_arg && (cnt1 >= cap)) begin
							st_kind = qat_pkg::KIND_TOO_MANY;
						end else if (n_in_quote) begin
							st_kind = qat_pkg::KIND_UNMATCHED;
						end else begin
							st_kind = qat_pkg::KIND_OK;
							if (n_in_arg) begin
								has_arg = 1'b1;
								arg_beg = n_begin;
								arg_end = pos_p1;
							end
						end
					end
				end
			end
		end

		arg_len   = arg_end - EXT_W'(arg_beg);
		cnt_after = arg_cnt_q + 5'(has_arg);
	end

	// Line state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q <= 1'b0;
			dbl_q      <= 1'b0;
			in_arg_q   <= 1'b0;
			begin_q    <= '0;
			pos_q      <= '0;
			arg_cnt_q  <= '0;
			stopped_q  <= 1'b0;
		end else if (fire_s1) begin
			if (line_end) begin
				in_quote_q <= 1'b0;
				dbl_q      <= 1'b0;
				in_arg_q   <= 1'b0;
				begin_q    <= '0;
				pos_q      <= '0;
				arg_cnt_q  <= '0;
				stopped_q  <= 1'b0;
			end else begin
				in_quote_q <= n_in_quote;
				dbl_q      <= n_dbl;
				in_arg_q   <= n_in_arg;
				begin_q    <= n_begin;
				pos_q      <= pos_q + POS_W'(1);
				arg_cnt_q  <= cnt_after;
				stopped_q  <= stopped_q | has_st;
			end
		end
	end

	// Result beats for this byte
	qat_pkg::result_t r_arg;
	qat_pkg::result_t r_st;

	always_comb begin
		r_arg.kind        = qat_pkg::KIND_ARG;
		r_arg.arg_start   = arg_beg;
		r_arg.arg_length  = arg_len[8:0];
		r_arg.arg_index   = arg_cnt_q[3:0];
		r_arg.arg_total   = cnt_after;
		r_arg.last_result = 1'b0;

		r_st.kind         = st_kind;
		r_st.arg_start    = '0;
		r_st.arg_length   = '0;
		r_st.arg_index    = '0;
		r_st.arg_total    = cnt_after;
		r_st.last_result  = 1'b1;
	end

	// Result queue, four entries
	qat_pkg::result_t q_mem [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic       push_arg;
	logic       push_st;
	logic [1:0] push_n;
	logic       pop;
	logic [1:0] st_ptr;

	assign push_arg = fire_s1 && has_arg;
	assign push_st  = fire_s1 && has_st;
	assign push_n   = 2'(push_arg) + 2'(push_st);
	assign pop      = m_axis_tvalid && m_axis_tready;
	assign st_ptr   = wr_ptr_q + 2'(push_arg);

	always_ff @(posedge clk) begin
		if (push_arg) begin
			q_mem[wr_ptr_q] <= r_arg;
		end
		if (push_st) begin
			q_mem[st_ptr] <= r_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			q_count_q <= '0;
		end else begin
			wr_ptr_q  <= wr_ptr_q + push_n;
			rd_ptr_q  <= rd_ptr_q + 2'(pop);
			q_count_q <= q_count_q + 3'(push_n) - 3'(pop);
		end
	end

	// Output beat from queue head
	qat_pkg::result_t head;
	assign head          = q_mem[rd_ptr_q];
	assign m_axis_tvalid = (q_count_q != 3'd0);
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last_result;
	assign m_axis_tdata  = {6'd0, head.arg_total, head.arg_index, head.arg_length,
	                        head.arg_start};

endmodule

// ----- tb/sv/quoted_argument_tokenizer_core_test.sv -----
`timescale 1ns / 1ps

module quoted_argument_tokenizer_core_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_STALL     = 300;
	localparam int DRAIN_CYCLES   = 6;
	localparam int FORCED_END_POS = 255;

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} char_beat_t;

	typedef enum int {
		LINE_WELL,
		LINE_BROKEN,
		LINE_NOISE,
		LINE_LONG
	} line_style_t;

	// DUT ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// stimulus and scoreboard
	char_beat_t        byte_q[$];
	logic [7:0]        line_buf[$];
	qat_pkg::result_t  token_q[$];

	// tokenizer state mirror
	logic        tk_in_quote = 1'b0;
	logic        tk_dq = 1'b0;
	logic        tk_in_arg = 1'b0;
	logic [7:0]  tk_begin = '0;
	logic [8:0]  tk_pos = '0;
	logic [4:0]  tk_count = '0;
	logic        tk_stopped = 1'b0;
	logic [4:0]  cap_reg = qat_pkg::MAX_ARGS_RESET;

	// handshake bookkeeping
	bit          in_taken = 1'b0;
	bit          out_taken = 1'b0;
	bit          calm = 1'b0;
	int          src_gap = 0;
	int          sink_hold = 0;
	int          stall_ask = 0;
	int          stall_seen = 0;
	int          idle_cycles = 0;

	// counters
	int          errors = 0;
	int          beats_out = 0;
	int          bytes_queued = 0;
	int          bytes_in = 0;
	int          lines_done = 0;
	int          cfg_writes = 0;
	int          kind_seen[4] = '{0, 0, 0, 0};

	quoted_argument_tokenizer_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),   // [7:0] char_byte
		.s_axis_tlast (s_axis_tlast),   // last_byte
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),   // [7:0] arg_start, [16:8] arg_length,
		                                // [20:17] arg_index, [25:21] arg_total
		.m_axis_tuser (m_axis_tuser),   // [1:0] kind
		.m_axis_tlast (m_axis_tlast)    // last_result
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Tokenizer prediction
	// ---------------------------------------------------------------
	function automatic logic [4:0] arg_capacity();
		return (cap_reg < qat_pkg::MAX_ARGS_RESET) ? cap_reg : qat_pkg::MAX_ARGS_RESET;
	endfunction

	task automatic push_arg(input logic [8:0] end_pos, output bit ok);
		qat_pkg::result_t r;
		ok = 1'b1;
		if (tk_count >= arg_capacity()) begin
			ok = 1'b0;
		end else begin
			r.kind        = qat_pkg::KIND_ARG;
			r.arg_start   = tk_begin;
			r.arg_length  = end_pos - {1'b0, tk_begin};
			r.arg_index   = tk_count[3:0];
			r.arg_total   = tk_count + 5'd1;
			r.last_result = 1'b0;
			token_q.push_back(r);
			tk_count++;
		end
	endtask

	task automatic push_status(input qat_pkg::kind_t k);
		qat_pkg::result_t r;
		r.kind        = k;
		r.arg_start   = '0;
		r.arg_length  = '0;
		r.arg_index   = '0;
		r.arg_total   = tk_count;
		r.last_result = 1'b1;
		token_q.push_back(r);
		tk_stopped = 1'b1;
	endtask

	// closes the line at a NUL or at its final byte
	task automatic finish_line(input logic [8:0] end_pos);
		bit ok;
		if (tk_in_arg && tk_count >= arg_capacity()) begin
			push_status(qat_pkg::KIND_TOO_MANY);
		end else if (tk_in_quote) begin
			push_status(qat_pkg::KIND_UNMATCHED);
		end else begin
			if (tk_in_arg)
				push_arg(end_pos, ok);
			push_status(qat_pkg::KIND_OK);
		end
	endtask

	task automatic predict_tokens(input logic [7:0] c, input logic lb);
		logic [8:0] p;
		bit         fin;
		bit         ok;
		p   = tk_pos;
		fin = lb || (p >= FORCED_END_POS);
		ok  = 1'b1;
		if (!tk_stopped) begin
			if (c == qat_pkg::CH_NUL) begin
				finish_line(p);
			end else begin
				if (tk_in_quote) begin
					// only the matching quote closes
					if (c == (tk_dq ? qat_pkg::CH_DQUOTE : qat_pkg::CH_SQUOTE)) begin
						push_arg(p, ok);
						tk_in_quote = 1'b0;
						tk_in_arg   = 1'b0;
					end
				end else if (c == qat_pkg::CH_SQUOTE || c == qat_pkg::CH_DQUOTE) begin
					// opening quote ends any bare word first
					if (tk_in_arg)
						push_arg(p, ok);
					tk_in_quote = 1'b1;
					tk_dq       = (c == qat_pkg::CH_DQUOTE);
					tk_in_arg   = 1'b1;
					tk_begin    = p[7:0] + 8'd1;
				end else if (c == qat_pkg::CH_SPACE) begin
					if (tk_in_arg) begin
						push_arg(p, ok);
						tk_in_arg = 1'b0;
					end
				end else if (!tk_in_arg) begin
					tk_in_arg = 1'b1;
					tk_begin  = p[7:0];
				end

				if (!ok)
					push_status(qat_pkg::KIND_TOO_MANY);
				else if (fin)
					finish_line(p + 9'd1);
			end
		end

		if (fin) begin
			tk_in_quote = 1'b0;
			tk_dq       = 1'b0;
			tk_in_arg   = 1'b0;
			tk_begin    = '0;
			tk_pos      = '0;
			tk_count    = '0;
			tk_stopped  = 1'b0;
			lines_done++;
		end else begin
			tk_pos = p + 9'd1;
		end
	endtask

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (errors < 40)
			$display("mismatch at result beat %0d: %s expected %0h got %0h",
				beats_out, what, want, got);
		errors++;
	endtask

	task automatic check_result();
		qat_pkg::result_t want;
		if (token_q.size() == 0) begin
			report_mismatch("unexpected beat, tdata", '0, m_axis_tdata);
		end else begin
			want = token_q.pop_front();
			if (m_axis_tuser !== want.kind)
				report_mismatch("kind", 32'(want.kind), 32'(m_axis_tuser));
			if (m_axis_tdata[7:0] !== want.arg_start)
				report_mismatch("arg_start", 32'(want.arg_start),
					32'(m_axis_tdata[7:0]));
			if (m_axis_tdata[16:8] !== want.arg_length)
				report_mismatch("arg_length", 32'(want.arg_length),
					32'(m_axis_tdata[16:8]));
			if (m_axis_tdata[20:17] !== want.arg_index)
				report_mismatch("arg_index", 32'(want.arg_index),
					32'(m_axis_tdata[20:17]));
			if (m_axis_tdata[25:21] !== want.arg_total)
				report_mismatch("arg_total", 32'(want.arg_total),
					32'(m_axis_tdata[25:21]));
			if (m_axis_tdata[31:26] !== 6'd0)
				report_mismatch("tdata pad", '0, 32'(m_axis_tdata[31:26]));
			if (m_axis_tlast !== want.last_result)
				report_mismatch("last_result", 32'(want.last_result), 32'(m_axis_tlast));
			kind_seen[want.kind]++;
		end
		beats_out++;
	endtask

	// monitor: both handshakes sampled at the rising edge, plus the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken  = s_axis_tvalid && s_axis_tready;
			out_taken = m_axis_tvalid && m_axis_tready;
			if (out_taken)
				check_result();
			if (in_taken) begin
				predict_tokens(s_axis_tdata, s_axis_tlast);
				bytes_in++;
			end
			if (in_taken || out_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", idle_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Driver and sink
	// ---------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// byte driver: holds a beat until taken, then idles for a random gap
	always @(negedge clk) begin : byte_driver
		char_beat_t b;
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (src_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					src_gap       <= src_gap - 1;
				end else if (byte_q.size() != 0) begin
					b = byte_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= b.ch;
					s_axis_tlast  <= b.lst;
					src_gap       <= pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink: random back-pressure, long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_ask != stall_seen) begin
				stall_seen    <= stall_ask;
				sink_hold     <= LONG_STALL;
				m_axis_tready <= 1'b0;
			end else if (sink_hold > 0) begin
				sink_hold     <= sink_hold - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				sink_hold     <= pick_gap();
			end
		end
	end

	// ---------------------------------------------------------------
	// Line generation
	// ---------------------------------------------------------------
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		while (c == qat_pkg::CH_SPACE || c == qat_pkg::CH_SQUOTE || c == qat_pkg::CH_DQUOTE)
			c = 8'($urandom_range(1, 255));
		return c;
	endfunction

	function automatic logic [7:0] noise_char();
		int         r;
		logic [7:0] c;
		r = $urandom_range(0, 15);
		c = 8'($urandom_range(0, 255));
		if (r == 0)
			c = qat_pkg::CH_NUL;
		else if (r == 1)
			c = qat_pkg::CH_SPACE;
		else if (r == 2)
			c = qat_pkg::CH_SQUOTE;
		else if (r == 3)
			c = qat_pkg::CH_DQUOTE;
		return c;
	endfunction

	// body of a quoted argument: spaces and the other quote are literal
	function automatic logic [7:0] quoted_char(input logic [7:0] q);
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return qat_pkg::CH_SPACE;
		if (r == 1)
			return (q == qat_pkg::CH_SQUOTE) ? qat_pkg::CH_DQUOTE : qat_pkg::CH_SQUOTE;
		return plain_char();
	endfunction

	task automatic text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	// queue the buffered line, tlast on its final byte
	task automatic flush_line();
		char_beat_t b;
		for (int i = 0; i < line_buf.size(); i++) begin
			b.ch  = line_buf[i];
			b.lst = (i == line_buf.size() - 1);
			byte_q.push_back(b);
			bytes_queued++;
		end
		line_buf.delete();
	endtask

	task automatic gen_line(input line_style_t style);
		int         ntok;
		int         len;
		int         kind;
		logic [7:0] q;
		line_buf.delete();
		case (style)
			LINE_NOISE: begin
				len = $urandom_range(1, 20);
				repeat (len) line_buf.push_back(noise_char());
			end
			LINE_LONG: begin
				// runs past the line length, so the block cuts it itself
				kind = $urandom_range(0, 1);
				repeat (300) begin
					if (kind == 0 || $urandom_range(0, 9) != 0)
						line_buf.push_back(plain_char());
					else
						line_buf.push_back(noise_char());
				end
			end
			default: begin
				ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 18)
					: $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0)
					line_buf.push_back(qat_pkg::CH_SPACE);
				for (int k = 0; k < ntok; k++) begin
					if (k > 0)
						repeat ($urandom_range(0, 2)) line_buf.push_back(qat_pkg::CH_SPACE);
					kind = $urandom_range(0, 2);
					if (kind == 0) begin
						repeat ($urandom_range(1, 6)) line_buf.push_back(plain_char());
					end else begin
						q = (kind == 1) ? qat_pkg::CH_SQUOTE : qat_pkg::CH_DQUOTE;
						line_buf.push_back(q);
						repeat ($urandom_range(0, 5)) line_buf.push_back(quoted_char(q));
						line_buf.push_back(q);
					end
				end
				// broken line: a quote left open
				if (style == LINE_BROKEN) begin
					q = $urandom_range(0, 1) ? qat_pkg::CH_SQUOTE : qat_pkg::CH_DQUOTE;
					line_buf.push_back(q);
					repeat ($urandom_range(0, 4)) line_buf.push_back(quoted_char(q));
				end
				if ($urandom_range(0, 3) == 0)
					line_buf.push_back(qat_pkg::CH_SPACE);
				// NUL terminator followed by bytes that must be ignored
				if ($urandom_range(0, 4) == 0) begin
					line_buf.push_back(qat_pkg::CH_NUL);
					repeat ($urandom_range(0, 3)) line_buf.push_back(noise_char());
				end
			end
		endcase
		if (line_buf.size() == 0)
			line_buf.push_back(plain_char());
		flush_line();
	endtask

	// ---------------------------------------------------------------
	// Sequencing
	// ---------------------------------------------------------------
	task automatic drain_all();
		while (byte_q.size() != 0 || s_axis_tvalid || token_q.size() != 0)
			@(posedge clk);
		// bytes that give no result may still be in the pipeline
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cap_reg = v;
		cfg_writes++;
	endtask

	task automatic random_phase(input logic [4:0] cap, input int n_bytes,
		input bit quiet, input bit squeeze, input bit with_long);
		int start;
		int r;
		write_capacity(cap);
		calm = quiet;
		if (squeeze)
			stall_ask++;
		start = bytes_queued;
		if (with_long)
			gen_line(LINE_LONG);
		while (bytes_queued - start < n_bytes) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				gen_line(LINE_WELL);
			else if (r < 85)
				gen_line(LINE_BROKEN);
			else
				gen_line(LINE_NOISE);
		end
		drain_all();
		calm = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed lines at the reset capacity
		text("a"); flush_line();
		text("\"\""); flush_line();                      // empty quoted argument
		text("ab'c d'"); flush_line();                   // quote ends a bare word
		text("x"); line_buf.push_back(qat_pkg::CH_NUL); text("y"); flush_line();
		text("'ab"); flush_line();                       // unmatched quote
		line_buf.push_back(qat_pkg::CH_NUL); flush_line();
		line_buf.push_back(8'hFF); line_buf.push_back(qat_pkg::CH_SPACE);
		line_buf.push_back(8'h01); flush_line();
		text(" "); flush_line();
		text("\"it's\""); flush_line();
		drain_all();

		// capacity one: overflow on a word, on a quote and at an open quote
		write_capacity(5'd1);
		text("a b"); flush_line();
		text("a 'b"); flush_line();
		text("'x'\"y\""); flush_line();
		drain_all();

		// capacity zero: the first argument is already too many
		write_capacity(5'd0);
		text("a"); flush_line();
		line_buf.push_back(qat_pkg::CH_NUL); flush_line();
		text(" "); flush_line();
		drain_all();

		// random phases across the capacity range
		random_phase(5'd16, 200, 1'b0, 1'b1, 1'b1);
		random_phase(5'd31, 200, 1'b1, 1'b0, 1'b0);
		random_phase(5'd3, 200, 1'b0, 1'b0, 1'b0);
		random_phase(5'd1, 200, 1'b0, 1'b0, 1'b0);
		random_phase(5'd17, 200, 1'b0, 1'b1, 1'b1);
		random_phase(5'($urandom_range(4, 15)), 200, 1'b0, 1'b0, 1'b0);
		random_phase(5'd0, 150, 1'b0, 1'b0, 1'b0);
		random_phase(5'd2, 200, 1'b1, 1'b0, 1'b0);
		random_phase(5'($urandom_range(5, 16)), 250, 1'b0, 1'b0, 1'b1);

		drain_all();
		if (token_q.size() != 0)
			report_mismatch("results never delivered, count", token_q.size(), '0);

		$display("covered %0d bytes in %0d lines over %0d capacity writes",
			bytes_in, lines_done, cfg_writes);
		$display("results: %0d arguments, %0d ok, %0d too many, %0d unmatched quote",
			kind_seen[qat_pkg::KIND_ARG], kind_seen[qat_pkg::KIND_OK],
			kind_seen[qat_pkg::KIND_TOO_MANY], kind_seen[qat_pkg::KIND_UNMATCHED]);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
